>>> src/rpq_pkg.sv
// Package for the RGB to palette quantizer: constants, types and helper functions.
// It has no dependencies. The lookup module and the top level import it.
package rpq_pkg;

  localparam int FullScale  = 255;
  localparam int CubeMax    = 5;
  localparam int CubeSteps  = 6;
  localparam int CubeStep   = FullScale / CubeMax;
  localparam int GrayDiv    = 39;
  localparam int GrayCount  = 40;
  localparam int GrayBase   = 215;
  localparam int GrayFirst  = 1;
  localparam int GrayLast   = GrayCount - 2;
  localparam int SumDepth   = 3 * 256 - 2;
  localparam int SumW       = $clog2(SumDepth);
  localparam int GrayW      = $clog2(GrayCount);

  typedef logic [SumW-1:0]  sum_t;
  typedef logic [GrayW-1:0] gray_t;

  typedef enum logic {
    LUT_FILL,
    LUT_RUN
  } lut_state_t;

  typedef struct packed {
    logic en;
    sum_t addr;
  } rd_req_t;

  function automatic logic [7:0] widen5(input logic [7:0] c);
    return {c[7:3], c[7:5]};
  endfunction

  function automatic logic [7:0] cube_level(input logic [2:0] q);
    return 8'(int'(q) * CubeStep);
  endfunction

  function automatic logic [2:0] cube_q(input logic [7:0] w);
    logic [2:0] q;
    logic [9:0] mid;
    q = '0;
    for (int i = 0; i < CubeMax; i++) begin
      mid = 10'(i * CubeStep) + 10'((i + 1) * CubeStep);
      if ({1'b0, w, 1'b0} > mid) begin
        q = q + 3'd1;
      end
    end
    return q;
  endfunction

  // The gray levels form a constant table, one entry per ramp step.
  function automatic logic [7:0] gray_level(input gray_t k);
    logic [7:0] v;
    v = '0;
    for (int i = 0; i < GrayCount; i++) begin
      if (k == gray_t'(i)) begin
        v = 8'((i * FullScale) / GrayDiv);
      end
    end
    return v;
  endfunction

endpackage

>>> src/rpq_gray_lut.sv
// Gray ramp lookup memory indexed by the channel sum, filled by a sweep after reset.
// Depends on rpq_pkg for the gray levels, the state type and the read request struct.
module rpq_gray_lut
  import rpq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  rd_req_t rd_req,
  output gray_t   rd_data,
  output logic    ready
);

  gray_t      mem [SumDepth];
  lut_state_t state_r, state_nxt;
  sum_t       addr_r, addr_nxt;
  gray_t      k_r, k_nxt;
  gray_t      k_fill;
  logic       wr_en;
  logic [11:0] thr;
  logic [11:0] twice_sum;
  gray_t      rd_data_r;

  always_comb begin
    thr       = 12'(3 * (int'(gray_level(k_r)) + int'(gray_level(k_r + gray_t'(1)))));
    twice_sum = {1'b0, addr_r, 1'b0};
    if ((k_r < gray_t'(GrayLast)) && (thr < twice_sum)) begin
      k_fill = k_r + gray_t'(1);
    end else begin
      k_fill = k_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    k_nxt     = k_r;
    wr_en     = 1'b0;
    ready     = 1'b0;
    case (state_r)
      LUT_FILL: begin
        wr_en    = 1'b1;
        k_nxt    = k_fill;
        addr_nxt = addr_r + sum_t'(1);
        if (addr_r == sum_t'(SumDepth - 1)) begin
          state_nxt = LUT_RUN;
        end
      end
      LUT_RUN: begin
        ready = 1'b1;
      end
      default: begin
        state_nxt = LUT_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LUT_FILL;
      addr_r  <= '0;
      k_r     <= gray_t'(GrayFirst);
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_r] <= k_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data_r <= mem[rd_req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/rgb_to_palette_quantizer.sv
// Top level of the RGB to palette quantizer: three-stage pipeline around the gray lookup.
// Depends on rpq_pkg and rpq_gray_lut.
//
// One pixel is taken per clock while busy is low, and its palette index appears on
// out_palette_index with out_strobe once it has passed the v1_r, v2_r and out_strobe_r registers.
// The receiver cannot stall, so every result must be taken in the cycle it is shown. After
// reset, busy stays high while all 766 entries of the gray lookup memory are filled, one
// channel sum per cycle. The nearest cube colour is found per channel; the nearest gray
// comes from that memory, read with the channel sum as address, and the two are compared
// on squared distance with ties going to the smaller packed colour.
module rgb_to_palette_quantizer
  import rpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_strobe,
  output logic [7:0] out_palette_index
);

  logic       lut_ready;
  rd_req_t    rd_req;
  gray_t      gray_k;
  logic       accept;
  logic [7:0] w_r_in, w_g_in, w_b_in;

  logic       v1_r;
  logic [7:0] w1_r_r, w1_g_r, w1_b_r;
  logic [2:0] q1_r_r, q1_g_r, q1_b_r;

  logic [7:0]  gv;
  logic [7:0]  lr, lg, lb;
  logic [7:0]  dcr, dcg, dcb, dgr, dgg, dgb;

  logic        v2_r;
  logic [15:0] sc_r_r, sc_g_r, sc_b_r, sg_r_r, sg_g_r, sg_b_r;
  logic        key_less_r;
  logic [7:0]  idx_cube_r, idx_gray_r;

  logic [17:0] dist_cube, dist_gray;
  logic        pick_cube;

  logic        out_strobe_r;
  logic [7:0]  out_index_r;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign busy   = !lut_ready;
  assign accept = start && lut_ready;
  assign w_r_in = widen5(in_red);
  assign w_g_in = widen5(in_green);
  assign w_b_in = widen5(in_blue);

  assign rd_req.en   = accept;
  assign rd_req.addr = sum_t'(10'(w_r_in) + 10'(w_g_in) + 10'(w_b_in));

  rpq_gray_lut u_gray_lut (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (rd_req),
    .rd_data (gray_k),
    .ready   (lut_ready)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w1_r_r <= w_r_in;
      w1_g_r <= w_g_in;
      w1_b_r <= w_b_in;
      q1_r_r <= cube_q(w_r_in);
      q1_g_r <= cube_q(w_g_in);
      q1_b_r <= cube_q(w_b_in);
    end
  end

  always_comb begin
    gv  = gray_level(gray_k);
    lr  = cube_level(q1_r_r);
    lg  = cube_level(q1_g_r);
    lb  = cube_level(q1_b_r);
    dcr = absdiff(w1_r_r, lr);
    dcg = absdiff(w1_g_r, lg);
    dcb = absdiff(w1_b_r, lb);
    dgr = absdiff(w1_r_r, gv);
    dgg = absdiff(w1_g_r, gv);
    dgb = absdiff(w1_b_r, gv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      sc_r_r     <= 16'(dcr) * 16'(dcr);
      sc_g_r     <= 16'(dcg) * 16'(dcg);
      sc_b_r     <= 16'(dcb) * 16'(dcb);
      sg_r_r     <= 16'(dgr) * 16'(dgr);
      sg_g_r     <= 16'(dgg) * 16'(dgg);
      sg_b_r     <= 16'(dgb) * 16'(dgb);
      key_less_r <= {lr, lg, lb} < {gv, gv, gv};
      idx_cube_r <= 8'(int'(q1_r_r) * CubeSteps * CubeSteps + int'(q1_g_r) * CubeSteps
                       + int'(q1_b_r));
      idx_gray_r <= 8'(GrayBase + int'(gray_k));
    end
  end

  always_comb begin
    dist_cube = 18'(sc_r_r) + 18'(sc_g_r) + 18'(sc_b_r);
    dist_gray = 18'(sg_r_r) + 18'(sg_g_r) + 18'(sg_b_r);
    pick_cube = (dist_cube < dist_gray) || ((dist_cube == dist_gray) && key_less_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      out_index_r <= pick_cube ? idx_cube_r : idx_gray_r;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_palette_index = out_index_r;

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_palette_index <= 8'(GrayBase + GrayLast)))
    else $error("palette index out of range");

  a_no_result_while_filling: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe && !v1_r && !v2_r)
    else $error("pipeline active during lookup fill");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 v2_r)
    else $error("accepted request lost in pipeline");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for rgb_to_palette_quantizer: it drives pixel requests and compares
// each palette index with a built-in nearest-colour search over the 254-entry palette.
// It depends only on the top-level module of the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 12;
  localparam int RandomPixels = 1500;
  localparam int CubeLevels = 6;
  localparam int CubeEntries = 216;
  localparam int GrayBase = 215;
  localparam int PaletteSize = 254;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    int unsigned idle_after;
    bit wait_drain;
  } pixel_req_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] index;
  } palette_hit_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic out_strobe;
  logic [7:0] out_palette_index;

  pixel_req_t pixel_q[$];
  palette_hit_t expected_hit_q[$];
  int error_count = 0;
  int cycle_count = 0;
  int unsigned idle_left = 0;
  int unsigned held_idle = 0;

  rgb_to_palette_quantizer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_strobe       (out_strobe),
    .out_palette_index(out_palette_index)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int unsigned expand_channel(input logic [7:0] c);
    int unsigned c5;
    c5 = int'(c) >> 3;
    return ((c5 << 3) | (c5 >> 2)) & 8'hFF;
  endfunction

  function automatic logic [7:0] nearest_palette_index(input logic [7:0] red,
                                                       input logic [7:0] green,
                                                       input logic [7:0] blue);
    int unsigned pr, pg, pb, er, eg, eb, gray, sq_dist, key;
    int unsigned best_dist, best_key, best_idx;
    pr = expand_channel(red);
    pg = expand_channel(green);
    pb = expand_channel(blue);
    best_dist = '1;
    best_key = '1;
    best_idx = 0;
    for (int idx = 0; idx < PaletteSize; idx++) begin
      if (idx < CubeEntries) begin
        er = (idx / (CubeLevels * CubeLevels)) * 255 / 5;
        eg = ((idx / CubeLevels) % CubeLevels) * 255 / 5;
        eb = (idx % CubeLevels) * 255 / 5;
      end else begin
        gray = (idx - GrayBase) * 255 / 39;
        er = gray;
        eg = gray;
        eb = gray;
      end
      sq_dist = (pr - er) * (pr - er) + (pg - eg) * (pg - eg) + (pb - eb) * (pb - eb);
      key = (er << 16) | (eg << 8) | eb;
      if (sq_dist < best_dist || (sq_dist == best_dist && key < best_key)) begin
        best_dist = sq_dist;
        best_key = key;
        best_idx = idx;
      end
    end
    return 8'(best_idx);
  endfunction

  function automatic logic [7:0] clamp_byte(input int v);
    if (v < 0) begin
      return 8'd0;
    end
    if (v > 255) begin
      return 8'd255;
    end
    return 8'(v);
  endfunction

  task automatic queue_pixel(input int r, input int g, input int b, input int unsigned idle,
                             input bit drain);
    pixel_req_t req;
    req.red = 8'(r);
    req.green = 8'(g);
    req.blue = 8'(b);
    req.idle_after = idle;
    req.wait_drain = drain;
    pixel_q = {pixel_q, req};
  endtask

  function automatic int unsigned random_idle(input bit burst);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 55) begin
      return 0;
    end
    if (roll < 88) begin
      return $urandom_range(1, 3);
    end
    if (roll < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin : request_driver
    pixel_req_t req;
    palette_hit_t hit;
    bit ready;
    if (!rst_n) begin
      start <= 1'b0;
      in_red <= '0;
      in_green <= '0;
      in_blue <= '0;
      idle_left = 0;
    end else begin
      ready = !start;
      if (start && !busy) begin
        hit.red = in_red;
        hit.green = in_green;
        hit.blue = in_blue;
        hit.index = nearest_palette_index(in_red, in_green, in_blue);
        expected_hit_q = {expected_hit_q, hit};
        idle_left = held_idle;
        ready = 1'b1;
      end
      if (ready) begin
        if (idle_left == 0 && pixel_q.size() > 0 &&
            !(pixel_q[0].wait_drain && expected_hit_q.size() != 0)) begin
          req = pixel_q.pop_front();
          start <= 1'b1;
          in_red <= req.red;
          in_green <= req.green;
          in_blue <= req.blue;
          held_idle = req.idle_after;
        end else begin
          if (idle_left > 0) begin
            idle_left--;
          end
          start <= 1'b0;
          in_red <= 8'($urandom);
          in_green <= 8'($urandom);
          in_blue <= 8'($urandom);
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    palette_hit_t hit;
    if (rst_n && out_strobe) begin
      if (expected_hit_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual index %0d", $time,
                 out_palette_index);
        error_count++;
      end else begin
        hit = expected_hit_q.pop_front();
        if (out_palette_index !== hit.index) begin
          $display("%0t: pixel %02h%02h%02h index mismatch, expected %0d, actual %0d", $time,
                   hit.red, hit.green, hit.blue, hit.index, out_palette_index);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int base, mode;
    bit burst;
    // Corners of the cube, truncation edges and a ramp of grays.
    queue_pixel(0, 0, 0, 0, 1'b0);
    queue_pixel(255, 255, 255, 0, 1'b0);
    queue_pixel(255, 0, 0, 1, 1'b0);
    queue_pixel(0, 255, 0, 0, 1'b0);
    queue_pixel(0, 0, 255, 2, 1'b0);
    queue_pixel(255, 255, 0, 0, 1'b0);
    queue_pixel(0, 255, 255, 0, 1'b0);
    queue_pixel(255, 0, 255, 0, 1'b0);
    queue_pixel(7, 7, 7, 0, 1'b0);
    queue_pixel(8, 8, 8, 1, 1'b0);
    queue_pixel(8'hAA, 8'h55, 8'hAA, 0, 1'b0);
    queue_pixel(8'h55, 8'hAA, 8'h55, 0, 1'b0);
    queue_pixel(25, 76, 127, 0, 1'b0);
    queue_pixel(26, 77, 128, 0, 1'b0);
    for (int v = 24; v < 256; v += 24) begin
      queue_pixel(v, v, v, 0, 1'b0);
    end
    queue_pixel(247, 247, 247, 0, 1'b0);
    queue_pixel(200, 204, 208, 0, 1'b0);
    for (int i = 0; i < RandomPixels; i++) begin
      burst = (i % 300) < 50;
      mode = $urandom_range(0, 3);
      if (mode == 0) begin
        queue_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    random_idle(burst), (i == 0) || (i == RandomPixels / 2));
      end else if (mode == 1) begin
        base = $urandom_range(0, 255);
        queue_pixel(clamp_byte(base + int'($urandom_range(0, 24)) - 12),
                    clamp_byte(base + int'($urandom_range(0, 24)) - 12),
                    clamp_byte(base + int'($urandom_range(0, 24)) - 12),
                    random_idle(burst), (i == 0) || (i == RandomPixels / 2));
      end else if (mode == 2) begin
        base = $urandom_range(0, 255);
        queue_pixel(base, base, base, random_idle(burst),
                    (i == 0) || (i == RandomPixels / 2));
      end else begin
        queue_pixel(int'($urandom_range(0, 4)) * 51 + 21 + int'($urandom_range(0, 8)),
                    int'($urandom_range(0, 4)) * 51 + 21 + int'($urandom_range(0, 8)),
                    int'($urandom_range(0, 4)) * 51 + 21 + int'($urandom_range(0, 8)),
                    random_idle(burst), (i == 0) || (i == RandomPixels / 2));
      end
    end
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pixel_q.size() != 0 || start) begin
      @(posedge clk);
    end
    while (expected_hit_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/rpq_pkg.sv
src/rpq_gray_lut.sv
src/rgb_to_palette_quantizer.sv
tb/testbench.sv
